FILE: sv/fraction_to_repeating_decimal_unit_defines.svh
// Assertion macros of the fraction to recurring decimal unit, used by its division engine.
`ifndef FRACTION_TO_REPEATING_DECIMAL_UNIT_DEFINES_SVH
`define FRACTION_TO_REPEATING_DECIMAL_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define FRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("frd assertion failed");
// Condition must never be seen at a clock edge out of reset.
`define FRD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("frd forbidden condition seen");
`else
`define FRD_ASSERT(lbl, prop)
`define FRD_ASSERT_NEVER(lbl, cond)
`endif
`endif

FILE: sv/frd_pkg.sv
// Types and constants of the fraction to recurring decimal unit.
package frd_pkg;

  localparam int unsigned NUM_W       = 32;
  localparam int unsigned DEN_W       = 6;
  localparam int unsigned REM_W       = 6;
  localparam int unsigned POS_W       = 6;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned PROD_W      = 10;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  // radix-4 restoring division: two quotient bits per step
  localparam int unsigned DIV_STEPS   = NUM_W / 2;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS);
  localparam int unsigned RADIX       = 10;

  // one classified request as it sits in the queue
  typedef struct packed {
    logic [NUM_W-1:0] numerator;
    logic [DEN_W-1:0] denominator;
    logic             div_error;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DIGIT,
    S_REPLOOK,
    S_EMIT_INT,
    S_EMIT_DIG,
    S_ERR
  } back_state_e;

endpackage

FILE: sv/frd_in_if.sv
// Request channel: one fraction per request.
interface frd_in_if;
  logic                         valid;
  logic                         ready;
  logic [frd_pkg::NUM_W-1:0]    numerator;
  logic [frd_pkg::DEN_W-1:0]    denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

FILE: sv/frd_out_if.sv
// Result channel: integer quotient, then fractional digits.
interface frd_out_if;
  logic                      valid;
  logic                      ready;
  logic [frd_pkg::NUM_W-1:0] value;
  logic                      is_integer_part;
  logic                      in_repeat;
  logic                      div_error;
  logic                      last;

  modport source (output valid, output value, output is_integer_part, output in_repeat,
                  output div_error, output last, input ready);
  modport sink   (input valid, input value, input is_integer_part, input in_repeat,
                  input div_error, input last, output ready);
endinterface

FILE: sv/frd_ram.sv
// Generic single write port, single read port RAM with registered read.
module frd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/frd_front.sv
// Front end: accepts fractions and flags unusable denominators.
module frd_front #(
  parameter int unsigned MAX_DENOM = 63
) (
  frd_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output frd_pkg::job_t   push_job_o
);

  localparam logic [frd_pkg::DEN_W-1:0] MaxDen = frd_pkg::DEN_W'(MAX_DENOM);

  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;

  // zero or over-range denominator becomes a single error result
  always_comb begin
    push_job_o.numerator   = in_i.numerator;
    push_job_o.denominator = in_i.denominator;
    push_job_o.div_error   = (in_i.denominator == '0) || (in_i.denominator > MaxDen);
  end

endmodule

FILE: sv/frd_queue.sv
// Short FIFO between the front end and the division engine.
module frd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  frd_pkg::job_t push_job_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output frd_pkg::job_t pop_job_o
);

  localparam int unsigned Depth = frd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  frd_pkg::job_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

FILE: sv/frd_back.sv
// Division engine: integer quotient, digit loop with remainder table, result output.
`include "fraction_to_repeating_decimal_unit_defines.svh"

module frd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  frd_pkg::job_t pop_job_i,
  frd_out_if.source     out_o
);

  localparam int unsigned NumW   = frd_pkg::NUM_W;
  localparam int unsigned RemW   = frd_pkg::REM_W;
  localparam int unsigned PosW   = frd_pkg::POS_W;
  localparam int unsigned DigW   = frd_pkg::DIGIT_W;
  localparam int unsigned ProdW  = frd_pkg::PROD_W;
  localparam int unsigned CntW   = frd_pkg::CNT_W;
  localparam int unsigned Depth  = frd_pkg::TABLE_DEPTH;
  localparam int unsigned NMult  = 2 ** DigW;

  frd_pkg::back_state_e state_q, state_d;

  logic [NumW-1:0]            quo_q;
  logic [frd_pkg::DEN_W-1:0]  den_q;
  logic [RemW-1:0]            rem_q;
  logic [CntW-1:0]            cnt_q;
  logic [PosW-1:0]            ndig_q;
  logic [PosW-1:0]            k_q;
  logic [PosW-1:0]            rep_start_q;
  logic                       repeats_q;
  logic [Depth-1:0]           seen_q;

  logic                       out_valid_q;
  logic [NumW-1:0]            value_q;
  logic                       isint_q, rep_q, err_q, last_q;

  // control strobes
  logic            out_free, out_load;
  logic [NumW-1:0] ld_value;
  logic            ld_isint, ld_rep, ld_err, ld_last;
  logic            job_start, div_step, dig_step, pos_re, dig_re;
  logic [PosW-1:0] dig_raddr;

  // datapath nets
  logic [RemW:0]    r1, r2;
  logic             q1, q2;
  logic [RemW-1:0]  r1m, r2m;
  logic [ProdW-1:0] prod;
  logic [ProdW-1:0] mult [NMult];
  logic [DigW-1:0]  digit;
  logic [RemW-1:0]  rem_new;
  logic [PosW-1:0]  pos_rdata;
  logic [DigW-1:0]  dig_rdata;
  logic [PosW-1:0]  ndig_inc;

  assign out_free = !out_valid_q || out_o.ready;
  assign ndig_inc = ndig_q + 1'b1;

  // two restoring division steps per cycle
  always_comb begin
    r1  = {rem_q, quo_q[NumW-1]};
    q1  = (r1 >= {1'b0, den_q});
    r1m = q1 ? RemW'(r1 - {1'b0, den_q}) : r1[RemW-1:0];
    r2  = {r1m, quo_q[NumW-2]};
    q2  = (r2 >= {1'b0, den_q});
    r2m = q2 ? RemW'(r2 - {1'b0, den_q}) : r2[RemW-1:0];
  end

  // one decimal digit: compare remainder times ten against the multiples of den
  always_comb begin
    prod  = ProdW'({rem_q, 3'b000}) + ProdW'({rem_q, 1'b0});
    for (int k = 0; k < NMult; k++) begin
      mult[k] = ProdW'(den_q) * ProdW'(k);
    end
    digit = '0;
    for (int k = 1; k < frd_pkg::RADIX; k++) begin
      if (prod >= mult[k]) begin
        digit = DigW'(k);
      end
    end
    rem_new = RemW'(prod - mult[digit]);
  end

  // next state and strobes
  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    job_start   = 1'b0;
    div_step    = 1'b0;
    dig_step    = 1'b0;
    pos_re      = 1'b0;
    dig_re      = 1'b0;
    dig_raddr   = k_q;
    out_load    = 1'b0;
    ld_value    = '0;
    ld_isint    = 1'b0;
    ld_rep      = 1'b0;
    ld_err      = 1'b0;
    ld_last     = 1'b0;
    case (state_q)
      frd_pkg::S_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_job_i.div_error) begin
            state_d = frd_pkg::S_ERR;
          end else begin
            job_start = 1'b1;
            state_d   = frd_pkg::S_DIV;
          end
        end
      end
      frd_pkg::S_DIV: begin
        div_step = 1'b1;
        if (cnt_q == CntW'(frd_pkg::DIV_STEPS - 1)) begin
          state_d = frd_pkg::S_DIGIT;
        end
      end
      frd_pkg::S_DIGIT: begin
        if (rem_q == '0) begin
          state_d = frd_pkg::S_EMIT_INT;
        end else if (seen_q[rem_q]) begin
          pos_re  = 1'b1;
          state_d = frd_pkg::S_REPLOOK;
        end else if (ndig_q == '1) begin
          state_d = frd_pkg::S_EMIT_INT;
        end else begin
          dig_step = 1'b1;
        end
      end
      frd_pkg::S_REPLOOK: begin
        state_d = frd_pkg::S_EMIT_INT;
      end
      frd_pkg::S_EMIT_INT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_value = quo_q;
          ld_isint = 1'b1;
          ld_last  = (ndig_q == '0);
          if (ndig_q == '0) begin
            state_d = frd_pkg::S_IDLE;
          end else begin
            dig_re    = 1'b1;
            dig_raddr = PosW'(1);
            state_d   = frd_pkg::S_EMIT_DIG;
          end
        end
      end
      frd_pkg::S_EMIT_DIG: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_value = NumW'(dig_rdata);
          ld_rep   = repeats_q && (k_q >= rep_start_q);
          ld_last  = (k_q == ndig_q);
          if (k_q == ndig_q) begin
            state_d = frd_pkg::S_IDLE;
          end else begin
            dig_re    = 1'b1;
            dig_raddr = k_q + 1'b1;
          end
        end
      end
      frd_pkg::S_ERR: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_err   = 1'b1;
          ld_last  = 1'b1;
          state_d  = frd_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = frd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frd_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control counters, seen bits and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ndig_q      <= '0;
      k_q         <= '0;
      repeats_q   <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (job_start) begin
        cnt_q     <= '0;
        ndig_q    <= '0;
        repeats_q <= 1'b0;
        seen_q    <= '0;
      end
      if (div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (dig_step) begin
        ndig_q        <= ndig_inc;
        seen_q[rem_q] <= 1'b1;
      end
      if (state_q == frd_pkg::S_REPLOOK) begin
        repeats_q <= 1'b1;
      end
      if (dig_re) begin
        k_q <= dig_raddr;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (job_start) begin
      quo_q <= pop_job_i.numerator;
      den_q <= pop_job_i.denominator;
      rem_q <= '0;
    end
    if (div_step) begin
      quo_q <= {quo_q[NumW-3:0], q1, q2};
      rem_q <= r2m;
    end
    if (dig_step) begin
      rem_q <= rem_new;
    end
    if (state_q == frd_pkg::S_REPLOOK) begin
      rep_start_q <= pos_rdata;
    end
    if (out_load) begin
      value_q <= ld_value;
      isint_q <= ld_isint;
      rep_q   <= ld_rep;
      err_q   <= ld_err;
      last_q  <= ld_last;
    end
  end

  // first position of each remainder
  frd_ram #(
    .WIDTH (PosW),
    .DEPTH (Depth)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (dig_step),
    .waddr_i (rem_q),
    .wdata_i (ndig_inc),
    .re_i    (pos_re),
    .raddr_i (rem_q),
    .rdata_o (pos_rdata)
  );

  // fractional digits by position
  frd_ram #(
    .WIDTH (DigW),
    .DEPTH (Depth)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (dig_step),
    .waddr_i (ndig_inc),
    .wdata_i (digit),
    .re_i    (dig_re),
    .raddr_i (dig_raddr),
    .rdata_o (dig_rdata)
  );

  assign out_o.valid           = out_valid_q;
  assign out_o.value           = value_q;
  assign out_o.is_integer_part = isint_q;
  assign out_o.in_repeat       = rep_q;
  assign out_o.div_error       = err_q;
  assign out_o.last            = last_q;

  `FRD_ASSERT(a_load_when_free, out_load |-> out_free)
  `FRD_ASSERT(a_div_rem_below_den, (state_q == frd_pkg::S_DIV) |-> (rem_q < den_q))
  `FRD_ASSERT(a_emit_index_range, (state_q == frd_pkg::S_EMIT_DIG) |-> (k_q != '0 && k_q <= ndig_q))
  `FRD_ASSERT(a_repeat_start_set, (state_q == frd_pkg::S_EMIT_DIG && repeats_q) |-> (rep_start_q != '0))
  `FRD_ASSERT_NEVER(a_step_past_table, dig_step && ndig_q == '1)

endmodule

FILE: sv/fraction_to_repeating_decimal_unit.sv
// Top level of the fraction to recurring decimal unit.
// Usage:
//   in_i carries one fraction per request (numerator, denominator). out_o
//   returns the integer quotient first (is_integer_part set), then the
//   fractional digits in order; in_repeat marks digits of the recurring cycle,
//   last marks the final result. A zero denominator, or one above MAX_DENOM,
//   gives one result with div_error and last set and value zero.
// Timing:
//   A two-entry queue sits between the front end and the division engine, so
//   requests are taken while the engine is busy. Per fraction the engine
//   takes the request, runs the radix-4 integer division, produces the n
//   fractional digits (with an extra position table read when a cycle is
//   found), then issues n+1 results, one per cycle while the receiver is
//   ready. The digit loop and the single read port of the digit RAM set the
//   time per fraction.
// Reset and stalls:
//   Reset empties the queue and the output register. A stalled receiver holds
//   the output register; the engine waits, then the queue fills and in_i.ready
//   drops.
module fraction_to_repeating_decimal_unit #(
  parameter int unsigned MAX_DENOM = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  frd_in_if.sink    in_i,
  frd_out_if.source out_o
);

  logic          push_valid, push_ready;
  frd_pkg::job_t push_job;
  logic          pop_valid, pop_ready;
  frd_pkg::job_t pop_job;

  frd_front #(
    .MAX_DENOM (MAX_DENOM)
  ) u_front (
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  frd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  frd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_job_i   (pop_job),
    .out_o       (out_o)
  );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the fraction to recurring decimal unit.
`timescale 1ns / 100ps

module tb;

  localparam int unsigned NUM_W          = frd_pkg::NUM_W;
  localparam int unsigned DEN_W          = frd_pkg::DEN_W;
  localparam int unsigned REM_W          = frd_pkg::REM_W;
  localparam int unsigned DIGIT_W        = frd_pkg::DIGIT_W;
  localparam int unsigned TABLE_DEPTH    = frd_pkg::TABLE_DEPTH;
  localparam int unsigned RADIX          = frd_pkg::RADIX;
  localparam int unsigned MAX_DENOM      = 63;
  localparam int unsigned HALF_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned MAX_RESULTS    = 63;
  localparam int unsigned LONG_IDLE_MAX  = 40;
  localparam int unsigned ENGINE_CYCLES  = 150;
  localparam int unsigned ITEMS_BOUND    = 520;
  localparam int unsigned HOLD_OFF_LEN   = 400;
  localparam int unsigned TAIL_CYCLES    = 200;
  // slowest correct run, taken several times over
  localparam int unsigned CYCLE_LIMIT    = 4 * (ITEMS_BOUND *
    (MAX_RESULTS * (LONG_IDLE_MAX + 1) + ENGINE_CYCLES + LONG_IDLE_MAX) + HOLD_OFF_LEN);

  // one result as the unit should answer it
  typedef struct packed {
    logic [NUM_W-1:0] value;
    logic             is_integer_part;
    logic             in_repeat;
    logic             div_error;
    logic             last;
  } digit_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  frd_in_if  in_if ();
  frd_out_if out_if ();

  digit_result_t expected_digits[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  int unsigned   hold_off       = 0;
  bit            idle_en        = 1'b0;

  fraction_to_repeating_decimal_unit #(
    .MAX_DENOM(MAX_DENOM)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout: %0d results still awaited", $realtime, expected_digits.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // mismatch report: one line, counted
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input longint unsigned got,
                             input longint unsigned want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // long division of num/den, queueing every result it gives
  function automatic void expand_fraction(input logic [NUM_W-1:0] num,
                                          input logic [DEN_W-1:0] den);
    bit [TABLE_DEPTH-1:0] seen;
    int unsigned          first_pos [TABLE_DEPTH];
    logic [DIGIT_W-1:0]   digits [TABLE_DEPTH];
    logic [NUM_W-1:0]     rem;
    logic [NUM_W-1:0]     prod;
    logic [REM_W-1:0]     slot;
    int unsigned          ndig;
    int unsigned          rep_start;
    bit                   repeats;
    digit_result_t        r;
    seen      = '0;
    ndig      = 0;
    rep_start = 0;
    repeats   = 1'b0;
    r         = '0;
    // zero denominator, or one out of range, answers a single error
    if (den == '0 || den > MAX_DENOM) begin
      r.div_error = 1'b1;
      r.last      = 1'b1;
      expected_digits.push_back(r);
      return;
    end
    rem = num % den;
    while (rem != '0) begin
      slot = rem[REM_W-1:0];
      if (seen[slot]) begin
        repeats   = 1'b1;
        rep_start = first_pos[slot];
        break;
      end
      if (ndig >= TABLE_DEPTH - 1) break;
      ndig++;
      seen[slot]      = 1'b1;
      first_pos[slot] = ndig;
      prod            = rem * RADIX;
      digits[ndig]    = DIGIT_W'(prod / den);
      rem             = prod % den;
    end
    // integer quotient first, then the fractional digits
    r.value           = num / den;
    r.is_integer_part = 1'b1;
    r.last            = (ndig == 0);
    expected_digits.push_back(r);
    for (int unsigned k = 1; k <= ndig; k++) begin
      r                 = '0;
      r.value           = NUM_W'(digits[k]);
      r.in_repeat       = repeats && (k >= rep_start);
      r.last            = (k == ndig);
      expected_digits.push_back(r);
    end
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, LONG_IDLE_MAX);
  endfunction

  function automatic logic [NUM_W-1:0] random_numerator();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      1, 2, 3: return NUM_W'($urandom_range(0, 999));
      default: return NUM_W'($urandom);
    endcase
  endfunction

  function automatic logic [DEN_W-1:0] random_denominator();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll < 5) return DEN_W'($urandom_range(1, 10));
    return DEN_W'($urandom_range(1, MAX_DENOM));
  endfunction

  // offer one request, wait for it to be taken, then maybe idle
  task automatic send_fraction(input logic [NUM_W-1:0] num, input logic [DEN_W-1:0] den);
    int unsigned gap;
    in_if.valid       <= 1'b1;
    in_if.numerator   <= num;
    in_if.denominator <= den;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    expand_fraction(num, den);
    gap = idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // sender stops until every awaited result is in
  task automatic wait_for_results();
    in_if.valid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
  endtask

  // receiver: always ready, random stalls when idling is on, or a long hold-off when one is asked for
  initial begin : result_sink
    int unsigned run;
    bit          level;
    run   = 0;
    level = 1'b1;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        hold_off--;
      end else if (!idle_en) begin
        out_if.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            level = 1'b1;
            run   = $urandom_range(1, 8);
          end else begin
            level = 1'b0;
            run   = pick_gap() + 1;
          end
        end
        out_if.ready <= level;
        run--;
      end
    end
  end

  // result checker: each result against the oldest expectation
  always @(posedge clk_i) begin
    digit_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_digits.size() == 0) begin
        report_mismatch("unexpected result, value", out_if.value, 0);
      end else begin
        want = expected_digits.pop_front();
        check_field("value", out_if.value, want.value);
        check_field("is_integer_part", out_if.is_integer_part, want.is_integer_part);
        check_field("in_repeat", out_if.in_repeat, want.in_repeat);
        check_field("div_error", out_if.div_error, want.div_error);
        check_field("last", out_if.last, want.last);
      end
    end
  end

  // extremes, error, exact, purely and partly recurring expansions
  task automatic test_directed_fractions();
    idle_en = 1'b0;
    send_fraction(32'd0, 6'd1);
    send_fraction(32'hFFFF_FFFF, 6'd1);
    send_fraction(32'hFFFF_FFFF, 6'd0);
    send_fraction(32'd0, 6'd0);
    send_fraction(32'd12345, 6'd0);
    send_fraction(32'd0, 6'd7);
    send_fraction(32'd10, 6'd2);
    send_fraction(32'd1, 6'd2);
    send_fraction(32'd1, 6'd4);
    send_fraction(32'd1, 6'd32);
    send_fraction(32'd1, 6'd3);
    send_fraction(32'd1, 6'd6);
    send_fraction(32'd1, 6'd7);
    send_fraction(32'd22, 6'd7);
    send_fraction(32'd1, 6'd48);
    send_fraction(32'd1, 6'd49);
    send_fraction(32'd1, 6'd59);
    send_fraction(32'd1, 6'd60);
    send_fraction(32'd1, 6'd61);
    send_fraction(32'd1, 6'd62);
    send_fraction(32'd1, 6'd63);
    send_fraction(32'hFFFF_FFFF, 6'd63);
    send_fraction(32'hFFFF_FFFF, 6'd3);
    send_fraction(32'h8000_0000, 6'd61);
    wait_for_results();
  endtask

  // random fractions with idling on both sides
  task automatic test_random_fractions(input int unsigned count);
    idle_en = 1'b1;
    repeat (count) send_fraction(random_numerator(), random_denominator());
    wait_for_results();
  endtask

  // receiver holds off while requests keep coming, so the input stalls
  task automatic test_back_pressure(input int unsigned count);
    idle_en  = 1'b0;
    hold_off = HOLD_OFF_LEN;
    repeat (count) send_fraction(random_numerator(), DEN_W'($urandom_range(1, MAX_DENOM)));
    wait_for_results();
  endtask

  // requests back to back, receiver always ready
  task automatic test_back_to_back(input int unsigned count);
    idle_en = 1'b0;
    repeat (count) send_fraction(random_numerator(), random_denominator());
    wait_for_results();
  endtask

  initial begin
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.numerator   <= '0;
    in_if.denominator <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_fractions();
    test_random_fractions(197);
    test_back_pressure(12);
    test_back_to_back(40);
    test_random_fractions(197);

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_digits.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/frd_pkg.sv
sv/frd_in_if.sv
sv/frd_out_if.sv
sv/frd_ram.sv
sv/frd_front.sv
sv/frd_queue.sv
sv/frd_back.sv
sv/fraction_to_repeating_decimal_unit.sv
tb/sv/tb.sv
